[hw/rtl/jpeg_dht_lookup_table_builder_assert.svh]
// Assertion macros for the DHT lookup table builder.
// Defining NO_ASSERTIONS turns every use into an empty statement.
`ifndef JPEG_DHT_LOOKUP_TABLE_BUILDER_ASSERT_SVH
`define JPEG_DHT_LOOKUP_TABLE_BUILDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define JDHT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jdht assertion failed");
`define JDHT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jdht assertion failed");
`else
`define JDHT_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define JDHT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/jdht_pkg.sv]
// Shared constants and controller/datapath interface types for the DHT builder.
// No dependencies.
package jdht_pkg;

   localparam int CODE_BITS_DEF   = 16;
   localparam int MAX_SYMBOLS_DEF = 256;
   localparam int TABLE_COUNT_DEF = 4;

   localparam int ENT_W = 13;   // {length[4:0], symbol[7:0]}

   // parse phases
   localparam logic [2:0] PH_LEN_HI  = 3'd0;
   localparam logic [2:0] PH_LEN_LO  = 3'd1;
   localparam logic [2:0] PH_CLASS   = 3'd2;
   localparam logic [2:0] PH_COUNTS  = 3'd3;
   localparam logic [2:0] PH_SYMBOLS = 3'd4;

   // class/identifier bytes
   localparam logic [7:0] CLS_DC1 = 8'h00;
   localparam logic [7:0] CLS_DC2 = 8'h01;
   localparam logic [7:0] CLS_AC1 = 8'h10;
   localparam logic [7:0] CLS_AC2 = 8'h11;

   localparam logic [16:0] CODE_SAT = 17'h1FFFF;

   typedef struct packed {
      logic clr_step;
      logic accept;
      logic parse;
      logic look;
      logic skip;
      logic take;
      logic fill;
      logic put;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_lookup;
      logic sym_step;
      logic skip_more;
      logic fill_mid;
      logic fill_last;
      logic fill_is_end;
      logic end_fill;
      logic rsp_free;
   } sts_type;

endpackage

[hw/rtl/jpeg_dht_lookup_table_builder.sv]
// Top level of the DHT lookup table builder.
// Depends on jdht_pkg, jdht_ctrl and jdht_dpath.
//
// req channel: one word per segment byte (tuser 0) or per table lookup (tuser 1).
// A segment starts with the high byte of its big-endian length, flagged by segment_start.
// rsp channel: exactly one word per request word. For a byte, tlast marks the
// byte that ends the segment and tdata carries table_ignored / symbols_overflow.
// For a lookup, tdata carries code length (0 = empty) and symbol.
// A lookup or a header/count byte is answered after its parse step. A symbol
// byte first walks past the empty code lengths and fills the store entries
// between its code and the previous one; the last symbol also pads to the table
// end. Filling is bound by the single store write port.
// After reset the store is swept to zero, one entry per cycle, over all
// 2^(table index bits + CODE_BITS) entries (262144 with defaults); req_tready
// stays low meanwhile. A stalled rsp holds its word; the next request is taken
// and worked on and waits for the output register before it is answered.
module jpeg_dht_lookup_table_builder #(
   parameter int CODE_BITS   = jdht_pkg::CODE_BITS_DEF,
   parameter int MAX_SYMBOLS = jdht_pkg::MAX_SYMBOLS_DEF,
   parameter int TABLE_COUNT = jdht_pkg::TABLE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // segment_start, data_byte[7:0], table_pick[1:0],
                                    // code_prefix[15:0], zero pad
   input  logic        req_tuser,   // opcode: 0 segment byte, 1 lookup
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // code_length[4:0], symbol_value[7:0], table_ignored,
                                    // symbols_overflow, zero pad
   output logic        rsp_tlast    // segment_done
);

   jdht_pkg::cmd_type cmd;
   jdht_pkg::sts_type sts;

   jdht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   jdht_dpath #(
      .CODE_BITS   (CODE_BITS),
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .TABLE_COUNT (TABLE_COUNT)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

[hw/rtl/jdht_ctrl.sv]
// Sequencer for the DHT builder: clear pass, dispatch, code skip, fills, response.
// Depends on jdht_pkg and the assertion macro header.
`include "jpeg_dht_lookup_table_builder_assert.svh"

module jdht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  jdht_pkg::sts_type sts,
   output jdht_pkg::cmd_type cmd
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_PARSE = 4'd2;
   localparam logic [3:0] S_SKIP  = 4'd3;
   localparam logic [3:0] S_FILL  = 4'd4;
   localparam logic [3:0] S_PUT   = 4'd5;
   localparam logic [3:0] S_DONE  = 4'd6;

   logic [3:0] st_ff, st_in;

   always_comb begin
      st_in      = st_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (st_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) st_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               st_in      = S_PARSE;
            end
         end
         S_PARSE: begin
            priority if (sts.is_lookup) begin
               cmd.look = 1'b1;
               st_in    = S_DONE;
            end else if (sts.sym_step) begin
               st_in = S_SKIP;
            end else begin
               cmd.parse = 1'b1;
               st_in     = S_DONE;
            end
         end
         S_SKIP: begin
            // walk past empty code lengths, one per cycle
            if (sts.skip_more) begin
               cmd.skip = 1'b1;
            end else begin
               cmd.take = 1'b1;
               st_in    = sts.fill_mid ? S_FILL : S_PUT;
            end
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            if (sts.fill_last) st_in = sts.fill_is_end ? S_DONE : S_PUT;
         end
         S_PUT: begin
            cmd.put = 1'b1;
            st_in   = sts.end_fill ? S_FILL : S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               st_in        = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= S_CLEAR;
      else       st_ff <= st_in;
   end

   `JDHT_ASSERT_NEXT(a_clear_once, clock, reset, st_ff != S_CLEAR, st_ff != S_CLEAR)
   `JDHT_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, st_ff == S_IDLE && req_tvalid, st_ff == S_PARSE)
   `JDHT_ASSERT_NEXT(a_fill_exit, clock, reset, st_ff == S_FILL, st_ff == S_FILL || st_ff == S_PUT || st_ff == S_DONE)
   `JDHT_ASSERT_IMPL(a_put_after_take, clock, reset, st_ff == S_PUT, $past(st_ff) == S_SKIP || $past(st_ff) == S_FILL)

endmodule

[hw/rtl/jdht_dpath.sv]
// Datapath of the DHT builder: parse registers, canonical code state, table store.
// Depends on jdht_pkg; driven by jdht_ctrl commands.
module jdht_dpath #(
   parameter int CODE_BITS   = jdht_pkg::CODE_BITS_DEF,
   parameter int MAX_SYMBOLS = jdht_pkg::MAX_SYMBOLS_DEF,
   parameter int TABLE_COUNT = jdht_pkg::TABLE_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       req_tdata,
   input  logic              req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,
   output logic              rsp_tlast,
   input  jdht_pkg::cmd_type cmd,
   output jdht_pkg::sts_type sts
);

   localparam int TBL_W   = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
   localparam int AW      = TBL_W + CODE_BITS;
   localparam int SL_W    = $clog2(MAX_SYMBOLS + 1);
   localparam int ENT_W_L = jdht_pkg::ENT_W;

   // latched item
   logic        op_ff, op_in;
   logic        start_ff, start_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  pick_ff, pick_in;
   logic [15:0] prefix_ff, prefix_in;

   // parser and code state
   logic [2:0]           phase_ff, phase_in;
   logic [15:0]          bl_ff, bl_in;
   logic [7:0]           counts_ff [16];
   logic [7:0]           counts_in [16];
   logic [4:0]           ci_ff, ci_in;
   logic [11:0]          tot_ff, tot_in;
   logic [11:0]          rem_ff, rem_in;
   logic [SL_W-1:0]      sl_ff, sl_in;
   logic [16:0]          code_ff, code_in;
   logic [CODE_BITS-1:0] fstart_ff, fstart_in;
   logic [4:0]           psize_ff, psize_in;
   logic [7:0]           psym_ff, psym_in;
   logic                 act_vld_ff, act_vld_in;
   logic [TBL_W-1:0]     act_idx_ff, act_idx_in;

   // take / fill
   logic                 tk_fit_ff, tk_fit_in;
   logic [CODE_BITS-1:0] tk_addr_ff, tk_addr_in;
   logic [4:0]           tk_size_ff, tk_size_in;
   logic [CODE_BITS-1:0] fp_ff, fp_in;
   logic [CODE_BITS-1:0] flast_ff, flast_in;
   logic [ENT_W_L-1:0]   fent_ff, fent_in;
   logic                 fend_ff, fend_in;

   // result
   logic        done_ff, done_in;
   logic        ign_ff, ign_in;
   logic        over_ff, over_in;
   logic        look_ok_ff, look_ok_in;
   logic        rv_ff, rv_in;
   logic [15:0] rdata_ff, rdata_in;
   logic        rlast_ff, rlast_in;

   logic [AW-1:0] clr_ptr_ff, clr_ptr_in;

   logic [ENT_W_L-1:0] store [2**AW];
   logic [ENT_W_L-1:0] rd_q_ff;

   // combinational helpers
   logic [4:0]           size_c;
   logic                 fit_c;
   logic [15:0]          lalign_c;
   logic [CODE_BITS-1:0] addr_c;
   logic [16:0]          code_shl_c;
   logic [16:0]          code_inc_c;
   logic                 pick_ok_c;
   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   logic [ENT_W_L-1:0]   mem_wd;
   logic [AW-1:0]        look_addr;

   assign size_c     = ci_ff + 5'd1;
   assign fit_c      = (sl_ff != '0) && ((code_ff >> size_c) == 17'd0);
   assign lalign_c   = code_ff[15:0] << (5'd16 - size_c);
   assign addr_c     = lalign_c[15 -: CODE_BITS];
   assign code_shl_c = code_ff[16] ? jdht_pkg::CODE_SAT : {code_ff[15:0], 1'b0};
   assign code_inc_c = (code_ff == jdht_pkg::CODE_SAT) ? code_ff : code_ff + 17'd1;
   assign pick_ok_c  = {1'b0, pick_ff} < 3'(TABLE_COUNT);
   assign look_addr  = {pick_ff[TBL_W-1:0], prefix_ff[15 -: CODE_BITS]};

   always_comb begin
      logic [15:0] nb;
      logic [11:0] tot_v;
      logic        sel_vld;
      logic [1:0]  sel_idx;
      logic [2:0]  eff_phase;
      logic        fin;

      op_in = op_ff; start_in = start_ff; byte_in = byte_ff;
      pick_in = pick_ff; prefix_in = prefix_ff;
      phase_in = phase_ff; bl_in = bl_ff; counts_in = counts_ff; ci_in = ci_ff;
      tot_in = tot_ff; rem_in = rem_ff; sl_in = sl_ff; code_in = code_ff;
      fstart_in = fstart_ff; psize_in = psize_ff; psym_in = psym_ff;
      act_vld_in = act_vld_ff; act_idx_in = act_idx_ff;
      tk_fit_in = tk_fit_ff; tk_addr_in = tk_addr_ff; tk_size_in = tk_size_ff;
      fp_in = fp_ff; flast_in = flast_ff; fent_in = fent_ff; fend_in = fend_ff;
      done_in = done_ff; ign_in = ign_ff; over_in = over_ff; look_ok_in = look_ok_ff;
      rdata_in = rdata_ff; rlast_in = rlast_ff;
      clr_ptr_in = clr_ptr_ff;
      nb = bl_ff - 16'd1;
      tot_v = tot_ff + {4'd0, byte_ff};
      sel_vld = 1'b1;
      sel_idx = 2'd0;
      eff_phase = start_ff ? jdht_pkg::PH_LEN_HI : phase_ff;
      fin = (rem_ff == 12'd0) || (bl_ff == 16'd0);

      if (cmd.clr_step) clr_ptr_in = clr_ptr_ff + AW'(1);

      if (cmd.accept) begin
         op_in     = req_tuser;
         start_in  = req_tdata[0];
         byte_in   = req_tdata[8:1];
         pick_in   = req_tdata[10:9];
         prefix_in = req_tdata[26:11];
         done_in   = 1'b0;
         ign_in    = 1'b0;
         over_in   = 1'b0;
      end

      if (cmd.look) look_ok_in = pick_ok_c;

      if (cmd.parse) begin
         if (start_ff) psize_in = 5'd0;
         unique case (eff_phase)
            jdht_pkg::PH_LEN_HI: begin
               if (start_ff) begin
                  bl_in    = {byte_ff, 8'h00};
                  phase_in = jdht_pkg::PH_LEN_LO;
               end
            end
            jdht_pkg::PH_LEN_LO: begin
               nb = {bl_ff[15:8], byte_ff};
               nb = (nb >= 16'd2) ? nb - 16'd2 : 16'd0;
               bl_in    = nb;
               phase_in = jdht_pkg::PH_CLASS;
               if (nb == 16'd0) begin
                  phase_in = jdht_pkg::PH_LEN_HI;
                  done_in  = 1'b1;
               end
            end
            jdht_pkg::PH_CLASS: begin
               unique case (byte_ff)
                  jdht_pkg::CLS_DC1: sel_idx = 2'd0;
                  jdht_pkg::CLS_DC2: sel_idx = 2'd1;
                  jdht_pkg::CLS_AC1: sel_idx = 2'd2;
                  jdht_pkg::CLS_AC2: sel_idx = 2'd3;
                  default:           sel_vld = 1'b0;
               endcase
               if ({1'b0, sel_idx} >= 3'(TABLE_COUNT)) sel_vld = 1'b0;
               act_vld_in = sel_vld;
               act_idx_in = sel_idx[TBL_W-1:0];
               ign_in     = !sel_vld;
               ci_in      = 5'd0;
               tot_in     = 12'd0;
               bl_in      = nb;
               phase_in   = jdht_pkg::PH_COUNTS;
               if (nb == 16'd0) begin
                  phase_in = jdht_pkg::PH_LEN_HI;
                  done_in  = 1'b1;
               end
            end
            jdht_pkg::PH_COUNTS: begin
               counts_in[ci_ff[3:0]] = byte_ff;
               ci_in  = ci_ff + 5'd1;
               tot_in = tot_v;
               bl_in  = nb;
               if (ci_ff == 5'd15) begin
                  over_in   = tot_v > 12'(MAX_SYMBOLS);
                  sl_in     = (tot_v > 12'(MAX_SYMBOLS)) ? SL_W'(MAX_SYMBOLS)
                                                         : tot_v[SL_W-1:0];
                  rem_in    = tot_v;
                  ci_in     = 5'd0;
                  code_in   = 17'd0;
                  fstart_in = '0;
                  psize_in  = 5'd0;
                  phase_in  = (tot_v == 12'd0) ? jdht_pkg::PH_CLASS : jdht_pkg::PH_SYMBOLS;
               end
               if (nb == 16'd0) begin
                  phase_in = jdht_pkg::PH_LEN_HI;
                  done_in  = 1'b1;
               end
            end
            default: ;
         endcase
      end

      if (cmd.skip) begin
         ci_in   = ci_ff + 5'd1;
         code_in = code_shl_c;
      end

      if (cmd.take) begin
         if (counts_ff[ci_ff[3:0]] != 8'd0)
            counts_in[ci_ff[3:0]] = counts_ff[ci_ff[3:0]] - 8'd1;
         rem_in     = rem_ff - 12'd1;
         bl_in      = nb;
         if (sl_ff != '0) sl_in = sl_ff - SL_W'(1);
         tk_fit_in  = fit_c;
         tk_addr_in = addr_c;
         tk_size_in = size_c;
         code_in    = code_inc_c;
         // gap fill from the previous code up to this one
         fp_in      = fstart_ff;
         flast_in   = addr_c - CODE_BITS'(1);
         fent_in    = {psize_ff, psym_ff};
         fend_in    = 1'b0;
      end

      if (cmd.fill) fp_in = fp_ff + CODE_BITS'(1);

      if (cmd.put) begin
         if (tk_fit_ff) begin
            fstart_in = tk_addr_ff;
            psize_in  = tk_size_ff;
            psym_in   = byte_ff;
         end
         if (fin) begin
            // last code of the table: pad to the end
            fp_in    = tk_fit_ff ? tk_addr_ff : fstart_ff;
            flast_in = '1;
            fent_in  = tk_fit_ff ? {tk_size_ff, byte_ff} : {psize_ff, psym_ff};
            fend_in  = 1'b1;
            psize_in = 5'd0;
         end
         if (rem_ff == 12'd0) phase_in = jdht_pkg::PH_CLASS;
         if (bl_ff == 16'd0) begin
            phase_in = jdht_pkg::PH_LEN_HI;
            done_in  = 1'b1;
         end
      end

      if (cmd.load_rsp) begin
         if (op_ff) begin
            rdata_in = look_ok_ff ? {3'b000, rd_q_ff[7:0], rd_q_ff[12:8]} : 16'd0;
            rlast_in = 1'b0;
         end else begin
            rdata_in = {1'b0, over_ff, ign_ff, 13'd0};
            rlast_in = done_ff;
         end
      end

      rv_in = cmd.load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rv_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= jdht_pkg::PH_LEN_HI;
         bl_ff      <= '0;
         ci_ff      <= '0;
         tot_ff     <= '0;
         rem_ff     <= '0;
         sl_ff      <= '0;
         code_ff    <= '0;
         fstart_ff  <= '0;
         psize_ff   <= '0;
         psym_ff    <= '0;
         act_vld_ff <= 1'b0;
         act_idx_ff <= '0;
         rv_ff      <= 1'b0;
         clr_ptr_ff <= '0;
         for (int i = 0; i < 16; i++) counts_ff[i] <= 8'd0;
      end else begin
         phase_ff   <= phase_in;
         bl_ff      <= bl_in;
         ci_ff      <= ci_in;
         tot_ff     <= tot_in;
         rem_ff     <= rem_in;
         sl_ff      <= sl_in;
         code_ff    <= code_in;
         fstart_ff  <= fstart_in;
         psize_ff   <= psize_in;
         psym_ff    <= psym_in;
         act_vld_ff <= act_vld_in;
         act_idx_ff <= act_idx_in;
         rv_ff      <= rv_in;
         clr_ptr_ff <= clr_ptr_in;
         counts_ff  <= counts_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      start_ff   <= start_in;
      byte_ff    <= byte_in;
      pick_ff    <= pick_in;
      prefix_ff  <= prefix_in;
      tk_fit_ff  <= tk_fit_in;
      tk_addr_ff <= tk_addr_in;
      tk_size_ff <= tk_size_in;
      fp_ff      <= fp_in;
      flast_ff   <= flast_in;
      fent_ff    <= fent_in;
      fend_ff    <= fend_in;
      done_ff    <= done_in;
      ign_ff     <= ign_in;
      over_ff    <= over_in;
      look_ok_ff <= look_ok_in;
      rdata_ff   <= rdata_in;
      rlast_ff   <= rlast_in;
   end

   // table store: one write port, one registered read port
   always_comb begin
      mem_we = 1'b0;
      mem_wa = {act_idx_ff, tk_addr_ff};
      mem_wd = {tk_size_ff, byte_ff};
      priority if (cmd.clr_step) begin
         mem_we = 1'b1;
         mem_wa = clr_ptr_ff;
         mem_wd = '0;
      end else if (cmd.fill) begin
         mem_we = 1'b1;
         mem_wa = {act_idx_ff, fp_ff};
         mem_wd = fent_ff;
      end else if (cmd.put) begin
         mem_we = tk_fit_ff && act_vld_ff;
      end else begin
         mem_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) store[mem_wa] <= mem_wd;
      if (cmd.look) rd_q_ff <= store[look_addr];
   end

   assign sts.clr_last    = &clr_ptr_ff;
   assign sts.is_lookup   = op_ff;
   assign sts.sym_step    = !start_ff && (phase_ff == jdht_pkg::PH_SYMBOLS);
   assign sts.skip_more   = (ci_ff < 5'd15) && (counts_ff[ci_ff[3:0]] == 8'd0);
   assign sts.fill_mid    = fit_c && act_vld_ff && (psize_ff != 5'd0) && (addr_c > fstart_ff);
   assign sts.fill_last   = fp_ff == flast_ff;
   assign sts.fill_is_end = fend_ff;
   assign sts.end_fill    = ((rem_ff == 12'd0) || (bl_ff == 16'd0)) && act_vld_ff &&
                            (tk_fit_ff || (psize_ff != 5'd0));
   assign sts.rsp_free    = !rv_ff || rsp_tready;

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tlast  = rlast_ff;

endmodule
